// ----- src/sortu_pkg.sv -----
// ----------------------------------------------------------------------------
// sortu_pkg
// Shared constants and types for the sorting/dedup cell chain.
// ----------------------------------------------------------------------------
package sortu_pkg;

    localparam int DEPTH  = 16;
    localparam int VAL_W  = 8;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int UCNT_W = 5;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_INSERT = 3'b010,
        S_EMIT   = 3'b100
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic cmp;   // compare key against held entry, register flags
        logic ins;   // open a slot at the boundary and write the key
        logic emit;  // shift toward cell 0
    } ctl_t;

endpackage

// ----- src/sort_unique_bytes.sv -----
// ----------------------------------------------------------------------------
// sort_unique_bytes
// Collects a list of signed bytes, keeps the distinct ones in ascending
// order in a chain of cells, and streams them out on the last element.
// ----------------------------------------------------------------------------
//  channel  | signals                                       | handshake
//  ---------+-----------------------------------------------+----------------
//  input    | value[7:0] signed, last                       | start & !busy
//  result   | sorted_value[7:0] signed, final_res,          | result_valid
//           | unique_count[4:0], overflow                   | (one cycle)
//
//  Each input transfer first compares the key in every cell, then combines
//  the match flags and shifts the chain open for the new value.
//  After a last element the chain shifts out one value per cycle until every
//  distinct value is out; busy stays high during that time.
//  Reset empties the chain at once; no clearing pass is needed.
//  Results cannot be stalled: each one is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sort_unique_bytes
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sortu_pkg::VAL_W-1:0]  value,
    input  logic                                last,
    output logic                                result_valid,
    output logic signed [sortu_pkg::VAL_W-1:0]  sorted_value,
    output logic                                final_res,
    output logic [sortu_pkg::UCNT_W-1:0]        unique_count,
    output logic                                overflow
);

    sortu_pkg::state_t  state_reg;
    sortu_pkg::state_t  state_next;
    sortu_pkg::val_t    key_reg;
    logic               last_reg;
    sortu_pkg::cnt_t    count_reg;
    sortu_pkg::cnt_t    count_next;
    sortu_pkg::cnt_t    total_reg;
    sortu_pkg::cnt_t    total_next;
    logic               ovf_reg;
    logic               ovf_next;

    logic               res_valid_reg;
    logic               res_valid_next;
    sortu_pkg::val_t    res_value_reg;
    logic               res_final_reg;
    sortu_pkg::cnt_t    res_count_reg;
    logic               res_ovf_reg;

    sortu_pkg::ctl_t    ctl;
    sortu_pkg::val_t    key;
    logic               accept;
    logic               dup;
    logic               full;
    logic               do_ins;

    sortu_pkg::val_t    cell_value [sortu_pkg::DEPTH];
    logic [sortu_pkg::DEPTH-1:0] cell_valid;
    logic [sortu_pkg::DEPTH-1:0] cell_lt;
    logic [sortu_pkg::DEPTH-1:0] cell_eq;

    assign busy   = (state_reg != sortu_pkg::S_IDLE);
    assign accept = start && !busy;
    assign key    = busy ? key_reg : value;
    assign dup    = |cell_eq;
    assign full   = (count_reg == sortu_pkg::CNT_W'(sortu_pkg::DEPTH));
    assign do_ins = (state_reg == sortu_pkg::S_INSERT) && !dup && !full;

    assign ctl.cmp  = accept;
    assign ctl.ins  = do_ins;
    assign ctl.emit = (state_reg == sortu_pkg::S_EMIT);

    genvar gi;
    generate
        for (gi = 0; gi < sortu_pkg::DEPTH; gi++)
        begin : g_cell
            sortu_pkg::val_t pv;
            logic            pvld;
            logic            plt;
            sortu_pkg::val_t nv;
            logic            nvld;

            if (gi == 0)
            begin : g_head
                assign pv   = key;
                assign pvld = 1'b0;
                assign plt  = 1'b1;
            end
            else
            begin : g_body
                assign pv   = cell_value[gi-1];
                assign pvld = cell_valid[gi-1];
                assign plt  = cell_lt[gi-1];
            end

            if (gi == sortu_pkg::DEPTH - 1)
            begin : g_tail
                assign nv   = '0;
                assign nvld = 1'b0;
            end
            else
            begin : g_inner
                assign nv   = cell_value[gi+1];
                assign nvld = cell_valid[gi+1];
            end

            sortu_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (key),
                .prev_value (pv),
                .prev_valid (pvld),
                .prev_lt    (plt),
                .next_value (nv),
                .next_valid (nvld),
                .value      (cell_value[gi]),
                .valid      (cell_valid[gi]),
                .lt         (cell_lt[gi]),
                .eq         (cell_eq[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        res_valid_next = 1'b0;
        unique case (state_reg)
            sortu_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = sortu_pkg::S_INSERT;
                end
            end
            sortu_pkg::S_INSERT:
            begin
                if (do_ins)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (!dup && full)
                begin
                    ovf_next = 1'b1;
                end
                total_next = do_ins ? count_reg + 1'b1 : count_reg;
                state_next = last_reg ? sortu_pkg::S_EMIT : sortu_pkg::S_IDLE;
            end
            sortu_pkg::S_EMIT:
            begin
                res_valid_next = 1'b1;
                count_next     = count_reg - 1'b1;
                if (count_reg == sortu_pkg::CNT_W'(1))
                begin
                    // list done: drop the flag for the next one
                    ovf_next   = 1'b0;
                    state_next = sortu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sortu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sortu_pkg::S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= value;
            last_reg <= last;
        end
        if (ctl.emit)
        begin
            res_value_reg <= cell_value[0];
            res_final_reg <= (count_reg == sortu_pkg::CNT_W'(1));
            res_count_reg <= total_reg;
            res_ovf_reg   <= ovf_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign sorted_value = res_value_reg;
    assign final_res    = res_final_reg;
    assign unique_count = sortu_pkg::UCNT_W'(res_count_reg);
    assign overflow     = res_ovf_reg;

    // valid bits always form a prefix whose length is the entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(cell_valid) == int'(count_reg))
        && (((cell_valid + 1'b1) & cell_valid) == '0))
        else $error("chain valid bits out of step with entry count");

    // the chain is empty once the final result of a list is out
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_res) |-> (count_reg == '0) && !ovf_reg)
        else $error("chain not empty after final result");

    // results of one list come out strictly ascending
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !final_res) |=>
            result_valid && (sorted_value > $past(sorted_value)))
        else $error("results not strictly ascending");

    // emission always produces a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sortu_pkg::S_EMIT) |=> result_valid)
        else $error("emission cycle without result");

endmodule

// ----- src/sortu_cell.sv -----
// ----------------------------------------------------------------------------
// sortu_cell
// One entry of the sorted chain: holds a value and its valid bit, compares
// against the broadcast key, shifts right on insert and left on emission.
// ----------------------------------------------------------------------------
module sortu_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  sortu_pkg::ctl_t  ctl,
    input  sortu_pkg::val_t  key,
    input  sortu_pkg::val_t  prev_value,
    input  logic             prev_valid,
    input  logic             prev_lt,
    input  sortu_pkg::val_t  next_value,
    input  logic             next_valid,
    output sortu_pkg::val_t  value,
    output logic             valid,
    output logic             lt,
    output logic             eq
);

    sortu_pkg::val_t value_reg;
    sortu_pkg::val_t value_next;
    logic            valid_reg;
    logic            valid_next;
    logic            lt_reg;
    logic            lt_next;
    logic            eq_reg;
    logic            eq_next;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (ctl.cmp)
        begin
            lt_next = valid_reg && (value_reg < key);
            eq_next = valid_reg && (value_reg == key);
        end
        if (ctl.ins && !lt_reg)
        begin
            // first cell not below the key takes it, the rest move up
            if (prev_lt)
            begin
                value_next = key;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
        end
        if (ctl.emit)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule
